FILE: rtl/icp_pkg.sv
// Package for the IFF chunk stream parser: result type, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package icp_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_CHUNK  = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Four-character ids, first byte in bits 7:0
	localparam logic [31:0] TAG_FORM = 32'h4D524F46;
	localparam logic [31:0] TAG_LIST = 32'h5453494C;
	localparam logic [31:0] TAG_CAT  = 32'h20544143;

	localparam logic [31:0] HDR_OFFSET_FULL  = 32'd12;
	localparam logic [31:0] HDR_OFFSET_SHORT = 32'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tag;
		logic [31:0] size;
		logic [31:0] form_type;
		logic        has_form_type;
		logic [31:0] data_offset;
	} icp_result_t;

endpackage

`default_nettype wire

FILE: rtl/icp_parse.sv
// Byte-wise IFF parse state and combinational result decode.
`timescale 1ns / 1ps
`default_nettype none

module icp_parse import icp_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output icp_result_t      res,
	output logic             res_valid
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_SKIP,
		PH_IGNORE
	} phase_t;

	phase_t                 phase_q,   phase_d;
	logic [3:0]             cnt_q,     cnt_d;
	logic [31:0]            tag_q,     tag_d;
	logic [31:0]            size_q,    size_d;
	logic [31:0]            hdr_tag_q, hdr_tag_d;
	logic [OFFSET_BITS-1:0] off_q,     off_next;
	logic [32:0]            skip_q,    skip_d;

	logic [31:0] tag_shifted;
	logic [31:0] size_shifted;
	logic [32:0] skip_dec;
	logic [63:0] next_ext;

	assign tag_shifted  = {data_byte, tag_q[31:8]};
	assign size_shifted = {size_q[23:0], data_byte};
	assign skip_dec     = skip_q - 33'd1;
	assign off_next     = off_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	assign next_ext     = 64'(off_next);

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		tag_d     = tag_q;
		size_d    = size_q;
		hdr_tag_d = hdr_tag_q;
		skip_d    = skip_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HEADER: begin
				if (cnt_q < 4'd4 || cnt_q >= 4'd8) begin
					tag_d = tag_shifted;
				end else begin
					size_d = size_shifted;
				end
				if (cnt_q == 4'd3) begin
					hdr_tag_d = tag_shifted;
					tag_d     = '0;
					cnt_d     = 4'd4;
					if (tag_shifted != TAG_FORM && tag_shifted != TAG_LIST &&
							tag_shifted != TAG_CAT) begin
						res_valid = 1'b1;
						res.kind  = KIND_REJECT;
						res.tag   = tag_shifted;
						phase_d   = PH_IGNORE;
					end
				end else if (cnt_q >= 4'd11) begin
					res_valid         = 1'b1;
					res.kind          = KIND_HEADER;
					res.tag           = hdr_tag_q;
					res.size          = size_q;
					res.form_type     = tag_shifted;
					res.has_form_type = 1'b1;
					res.data_offset   = HDR_OFFSET_FULL;
					phase_d           = PH_CHUNK;
					cnt_d             = '0;
					tag_d             = '0;
					size_d            = '0;
				end else begin
					// file ends before the type tag is complete: header without type
					if (last_byte && cnt_q >= 4'd7) begin
						res_valid       = 1'b1;
						res.kind        = KIND_HEADER;
						res.tag         = hdr_tag_q;
						res.size        = size_d;
						res.data_offset = HDR_OFFSET_SHORT;
					end
					cnt_d = cnt_q + 4'd1;
				end
			end
			PH_CHUNK: begin
				if (cnt_q < 4'd4) begin
					tag_d = tag_shifted;
				end else begin
					size_d = size_shifted;
				end
				if (cnt_q >= 4'd7) begin
					res_valid       = 1'b1;
					res.kind        = KIND_CHUNK;
					res.tag         = tag_q;
					res.size        = size_shifted;
					res.data_offset = next_ext[31:0];
					// body plus pad byte on odd size
					skip_d  = {1'b0, size_shifted} + {32'd0, size_shifted[0]};
					phase_d = (size_shifted != 32'd0) ? PH_SKIP : PH_CHUNK;
					cnt_d   = '0;
					tag_d   = '0;
					size_d  = '0;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			PH_SKIP: begin
				if (skip_q != 33'd0) begin
					skip_d = skip_dec;
				end
				if (skip_q == 33'd0 || skip_dec == 33'd0) begin
					phase_d = PH_CHUNK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			cnt_q     <= '0;
			tag_q     <= '0;
			size_q    <= '0;
			hdr_tag_q <= '0;
			off_q     <= '0;
			skip_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q   <= PH_HEADER;
				cnt_q     <= '0;
				tag_q     <= '0;
				size_q    <= '0;
				hdr_tag_q <= '0;
				off_q     <= '0;
				skip_q    <= '0;
			end else begin
				phase_q   <= phase_d;
				cnt_q     <= cnt_d;
				tag_q     <= tag_d;
				size_q    <= size_d;
				hdr_tag_q <= hdr_tag_d;
				off_q     <= off_next;
				skip_q    <= skip_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/icp_out_fifo.sv
// Two-entry result queue that decouples the parser from the output channel.
`timescale 1ns / 1ps
`default_nettype none

module icp_out_fifo import icp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire icp_result_t  wr_data,
	output logic              not_full,
	output logic              rd_valid,
	input  wire logic         rd_ready,
	output icp_result_t       rd_data
);

	icp_result_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        rd_en;

	assign not_full = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/iff_chunk_stream_parser.sv
// Top level of the IFF chunk stream parser.
// Results pass through the registered two-entry result queue to the output.
// Throughput: one byte per cycle; the two-entry result queue keeps bytes flowing
// while a result waits, and in_ready drops only when both entries are held.
// Reset: arst_n clears parse state and the queue; the parser also returns to its
// start state after each transfer that carries last_byte.
`timescale 1ns / 1ps
`default_nettype none

module iff_chunk_stream_parser import icp_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [31:0]      tag,
	output logic [31:0]      size,
	output logic [31:0]      form_type,
	output logic             has_form_type,
	output logic [31:0]      data_offset
);

	logic        accept;
	logic        res_valid;
	icp_result_t res;
	icp_result_t head;

	assign accept = in_valid && in_ready;

	icp_parse #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res       (res),
		.res_valid (res_valid)
	);

	icp_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && res_valid),
		.wr_data  (res),
		.not_full (in_ready),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_data  (head)
	);

	assign kind          = head.kind;
	assign tag           = head.tag;
	assign size          = head.size;
	assign form_type     = head.form_type;
	assign has_form_type = head.has_form_type;
	assign data_offset   = head.data_offset;

endmodule

`default_nettype wire

FILE: sim/icp_checker.sv
// Checker for the IFF chunk stream parser: watches both channels, predicts results, compares.
`timescale 1ns / 1ps

module icp_checker import icp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] tag,
	input  logic [31:0] size,
	input  logic [31:0] form_type,
	input  logic        has_form_type,
	input  logic [31:0] data_offset,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef enum logic [1:0] {
		PH_FILE_HDR,
		PH_CHUNK_HDR,
		PH_BODY_SKIP,
		PH_DISCARD
	} parse_phase_t;

	parse_phase_t phase;
	int unsigned  nbytes;
	logic [31:0]  tag_acc;
	logic [31:0]  size_acc;
	logic [31:0]  file_tag;
	logic [31:0]  file_pos;
	logic [32:0]  skip_left;

	icp_result_t  pending_results[$];
	icp_result_t  oldest;
	icp_result_t  predicted;
	int           n_fail;
	int           n_checked;
	int           n_wrong;

	function automatic void clear_parser();
		phase     = PH_FILE_HDR;
		nbytes    = 0;
		tag_acc   = '0;
		size_acc  = '0;
		file_tag  = '0;
		file_pos  = '0;
		skip_left = '0;
	endfunction

	// Advance the parse by one byte; returns 1 when the byte completes a result.
	function automatic bit advance_parser(input logic [7:0] b, input logic lb,
			output icp_result_t r);
		bit          hit;
		logic [31:0] nxt;
		hit = 1'b0;
		r   = '0;
		nxt = file_pos + 32'd1;
		case (phase)
			PH_FILE_HDR: begin
				if (nbytes < 4 || nbytes >= 8)
					tag_acc = {b, tag_acc[31:8]};
				else
					size_acc = {size_acc[23:0], b};
				if (nbytes == 3) begin
					file_tag = tag_acc;
					tag_acc  = '0;
					if (file_tag != TAG_FORM && file_tag != TAG_LIST && file_tag != TAG_CAT) begin
						r.kind = KIND_REJECT;
						r.tag  = file_tag;
						hit    = 1'b1;
						phase  = PH_DISCARD;
					end
					nbytes = 4;
				end else if (nbytes >= 11) begin
					r.kind          = KIND_HEADER;
					r.tag           = file_tag;
					r.size          = size_acc;
					r.form_type     = tag_acc;
					r.has_form_type = 1'b1;
					r.data_offset   = HDR_OFFSET_FULL;
					hit      = 1'b1;
					phase    = PH_CHUNK_HDR;
					nbytes   = 0;
					tag_acc  = '0;
					size_acc = '0;
				end else begin
					// file ends before the type tag is complete: header without it
					if (lb && nbytes >= 7) begin
						r.kind        = KIND_HEADER;
						r.tag         = file_tag;
						r.size        = size_acc;
						r.data_offset = HDR_OFFSET_SHORT;
						hit = 1'b1;
					end
					nbytes = nbytes + 1;
				end
			end
			PH_CHUNK_HDR: begin
				if (nbytes < 4)
					tag_acc = {b, tag_acc[31:8]};
				else
					size_acc = {size_acc[23:0], b};
				if (nbytes >= 7) begin
					r.kind        = KIND_CHUNK;
					r.tag         = tag_acc;
					r.size        = size_acc;
					r.data_offset = nxt;
					hit       = 1'b1;
					skip_left = {1'b0, size_acc} + size_acc[0];
					phase     = (skip_left != 0) ? PH_BODY_SKIP : PH_CHUNK_HDR;
					nbytes    = 0;
					tag_acc   = '0;
					size_acc  = '0;
				end else begin
					nbytes = nbytes + 1;
				end
			end
			PH_BODY_SKIP: begin
				if (skip_left != 0)
					skip_left = skip_left - 33'd1;
				if (skip_left == 0)
					phase = PH_CHUNK_HDR;
			end
			default: ;
		endcase
		file_pos = nxt;
		if (lb)
			clear_parser();
		return hit;
	endfunction

	function automatic int field_mismatch(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			pending_results.delete();
			n_fail     = 0;
			n_checked  = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			// a result never leaves in the cycle its last byte goes in, so check first
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: kind %0d tag 0x%08h", kind, tag);
					n_fail = n_fail + 1;
				end else begin
					oldest  = pending_results.pop_front();
					n_wrong = 0;
					n_wrong += field_mismatch("kind", oldest.kind, kind);
					n_wrong += field_mismatch("tag", oldest.tag, tag);
					n_wrong += field_mismatch("size", oldest.size, size);
					n_wrong += field_mismatch("form_type", oldest.form_type, form_type);
					n_wrong += field_mismatch("has_form_type", oldest.has_form_type,
						has_form_type);
					n_wrong += field_mismatch("data_offset", oldest.data_offset, data_offset);
					if (n_wrong != 0)
						n_fail = n_fail + 1;
					n_checked = n_checked + 1;
				end
			end
			if (in_valid && in_ready) begin
				if (advance_parser(data_byte, last_byte, predicted))
					pending_results.push_back(predicted);
			end
			fail_count <= n_fail;
			pending    <= pending_results.size();
			checked    <= n_checked;
		end
	end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the IFF chunk stream parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import icp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [31:0] tag;
	logic [31:0] size;
	logic [31:0] form_type;
	logic        has_form_type;
	logic [31:0] data_offset;

	int fail_count;
	int results_pending;
	int results_checked;

	logic [7:0] file_bytes[$];
	int         bytes_sent;
	int         files_sent;
	bit         no_gaps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	iff_chunk_stream_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tag           (tag),
		.size          (size),
		.form_type     (form_type),
		.has_form_type (has_form_type),
		.data_offset   (data_offset)
	);

	icp_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tag           (tag),
		.size          (size),
		.form_type     (form_type),
		.has_form_type (has_form_type),
		.data_offset   (data_offset),
		.fail_count    (fail_count),
		.pending       (results_pending),
		.checked       (results_checked)
	);

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic void push_id(input logic [31:0] id);
		for (int k = 0; k < 4; k++)
			file_bytes.push_back(id[8*k +: 8]);
	endfunction

	function automatic void push_be32(input logic [31:0] v);
		for (int k = 3; k >= 0; k--)
			file_bytes.push_back(v[8*k +: 8]);
	endfunction

	function automatic void push_noise(input int n);
		for (int k = 0; k < n; k++)
			file_bytes.push_back($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] pick_file_tag();
		case ($urandom_range(0, 2))
			0: return TAG_FORM;
			1: return TAG_LIST;
			default: return TAG_CAT;
		endcase
	endfunction

	// Container with a full header and a run of chunks; the ending is varied.
	function automatic void build_container();
		int          n_chunks;
		int          r;
		bit          open_end;
		logic [31:0] csize;
		file_bytes.delete();
		push_id(pick_file_tag());
		push_be32($urandom);
		push_id($urandom);
		n_chunks = $urandom_range(0, 5);
		open_end = 1'b0;
		for (int i = 0; i < n_chunks && !open_end; i++) begin
			push_id(($urandom_range(0, 4) == 0) ? TAG_FORM : $urandom);
			r = $urandom_range(0, 19);
			if (r == 0) begin
				// body runs past the end of the file
				csize    = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
				open_end = 1'b1;
				push_be32(csize);
				push_noise($urandom_range(0, 12));
			end else begin
				csize = $urandom_range(0, 24);
				push_be32(csize);
				push_noise(csize + csize[0]);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 2)
			push_noise($urandom_range(1, 7));
		else if (r < 4 && file_bytes.size() > 13)
			repeat ($urandom_range(1, 6)) void'(file_bytes.pop_back());
	endfunction

	function automatic void build_short();
		int len;
		file_bytes.delete();
		push_id(pick_file_tag());
		push_be32($urandom);
		push_id($urandom);
		len = $urandom_range(1, 11);
		while (file_bytes.size() > len)
			void'(file_bytes.pop_back());
	endfunction

	function automatic void build_bad_tag();
		file_bytes.delete();
		if ($urandom_range(0, 1) == 0)
			push_id(pick_file_tag() ^ (32'd1 << $urandom_range(0, 31)));
		else
			push_id($urandom);
		push_noise($urandom_range(0, 10));
	endfunction

	task automatic send_file();
		int gap;
		for (int i = 0; i < file_bytes.size(); i++) begin
			gap = no_gaps ? 0 : pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= file_bytes[i];
			last_byte <= (i == file_bytes.size() - 1);
			do @(posedge clk); while (!in_ready);
			bytes_sent++;
		end
		files_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	// sender
	initial begin
		int r;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_byte  <= 8'h00;
		last_byte  <= 1'b0;
		bytes_sent = 0;
		files_sent = 0;
		no_gaps    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad tag, all ones
		file_bytes.delete();
		push_id(32'hFFFF_FFFF);
		file_bytes.push_back(8'h00);
		send_file();
		// header without type tag, ends on the size field
		file_bytes.delete();
		push_id(TAG_CAT);
		push_be32(32'h0000_0000);
		send_file();
		// too short for any result
		file_bytes.delete();
		file_bytes.push_back(8'h46);
		file_bytes.push_back(8'hFF);
		send_file();
		// full header, nested FORM chunk whose header ends on the last byte
		file_bytes.delete();
		push_id(TAG_FORM);
		push_be32(32'hFFFF_FFFF);
		push_id(32'h0000_0000);
		push_id(TAG_FORM);
		push_be32(32'd3);
		send_file();
		wait_drained();

		while (bytes_sent < 1350) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 7)
				build_container();
			else if (r < 8)
				build_short();
			else if (r < 9)
				build_bad_tag();
			else begin
				file_bytes.delete();
				push_noise($urandom_range(1, 24));
			end
			send_file();
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("tb_top: %0d files, %0d bytes sent; %0d results checked", files_sent,
			bytes_sent, results_checked);
		$display("tb_top: headers, chunk walks, rejects, short and truncated files covered");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// receiver: random stalls, two long holds to back up the result queue
	initial begin
		int k;
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		k = 0;
		forever begin
			if (k == 25 || k == 150) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(30, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			k++;
		end
	end

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/icp_pkg.sv
rtl/icp_parse.sv
rtl/icp_out_fifo.sv
rtl/iff_chunk_stream_parser.sv
sim/icp_checker.sv
sim/tb_top.sv
